// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the PPM frame decoder.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ppm_pkg.sv =====
// Package for the PPM frame decoder: item kinds, register indexes, reset values.
// No dependencies; imported by ppm_chan_store, ppm_frame_decoder and the bench modules.
package ppm_pkg;

  // Item kinds carried in the input beat's tuser
  typedef enum logic [1:0] {
    ACT_CAPTURE = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_READ    = 2'd2
  } action_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DECODER_ON = 3'd0,
    REG_MIN_PULSE  = 3'd1,
    REG_MAX_PULSE  = 3'd2,
    REG_SYNC_THR   = 3'd3,
    REG_TIMEOUT    = 3'd4
  } cfg_reg_t;

  // Field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WIDTH_W = 16;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned CFG_W   = 16;

  // Reset values
  localparam logic [WIDTH_W-1:0] CENTER_US       = 16'd1500;
  localparam logic [CFG_W-1:0]   RST_MIN_PULSE   = 16'd800;
  localparam logic [CFG_W-1:0]   RST_MAX_PULSE   = 16'd2200;
  localparam logic [CFG_W-1:0]   RST_SYNC_THR    = 16'd3000;
  localparam logic [CFG_W-1:0]   RST_TIMEOUT     = 16'd100;

endpackage

// ===== sv/ppm_chan_store.sv =====
// Channel width store: one-port-write, one-port-read memory with registered read.
// Depends on ppm_pkg; per-entry valid bits make unwritten entries read as centre.
module ppm_chan_store
  import ppm_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [WIDTH_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [WIDTH_W-1:0] rd_data
);

  logic [WIDTH_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld;
  logic [WIDTH_W-1:0] rd_word;
  logic               rd_vld;

  // Write and read the array; read data held until the next read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // Unwritten entries read as the stick centre
  assign rd_data = rd_vld ? rd_word : CENTER_US;

endmodule

// ===== sv/ppm_frame_decoder.sv =====
// PPM frame decoder top level: capture widths, frame tracking, channel reads.
// Depends on ppm_pkg, ppm_chan_store and assert_macros.svh.
// Path: an accepted item goes to stage one, then to the output register on m_tdata.
// Throughput: one item per cycle while m_tready is high; one store access per cycle.
// Reset (rst, synchronous): registers to defaults, store valid bits cleared at once,
// so the channel store needs no clearing pass and items are taken right after reset.
`include "assert_macros.svh"

module ppm_frame_decoder
  import ppm_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // input beat
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] capture_time, [35:32] channel_index, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] action
  // result beat
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [15:0] channel_value, [16] signal_ok,
                                 // [20:17] channel_count, [52:21] capture_count,
                                 // [84:53] ms_since_frame, rest zero
  output logic        m_tlast,   // frame_complete
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CW = $clog2(MAX_CHANNELS + 1);

  // Configuration registers
  logic               decoder_on;
  logic [CFG_W-1:0]   min_pulse;
  logic [CFG_W-1:0]   max_pulse;
  logic [CFG_W-1:0]   sync_thr;
  logic [CFG_W-1:0]   timeout;

  // Decoder state
  logic [CW-1:0]      next_channel;
  logic [CW-1:0]      frame_channels;
  logic [WIDTH_W-1:0] prev_capture;
  logic               frame_seen;
  logic [TIME_W-1:0]  capture_count;
  logic [TIME_W-1:0]  now_ms;
  logic [TIME_W-1:0]  last_frame_ms;

  // Pipeline registers
  logic               s1_valid;
  logic               s1_hit;
  logic               s1_closed;
  logic               out_valid;
  logic [WIDTH_W-1:0] out_value;
  logic               out_ok;
  logic [COUNT_W-1:0] out_count;
  logic               out_closed;
  logic [TIME_W-1:0]  out_captures;
  logic [TIME_W-1:0]  out_since;

  // Decode of the incoming beat
  action_t            action;
  logic [TIME_W-1:0]  capture_time;
  logic [IDX_W-1:0]   channel_index;
  logic               accept;
  logic               s1_adv;
  logic               take_cap;
  logic [WIDTH_W-1:0] pulse_w;
  logic               is_sync;
  logic               is_pulse;
  logic               room;
  logic               store_wr;
  logic               store_rd;
  logic [WIDTH_W-1:0] store_data;
  logic [TIME_W-1:0]  since;
  logic               ok_now;
  cfg_reg_t           cfg_reg;

  assign action        = action_t'(s_tuser);
  assign capture_time  = s_tdata[31:0];
  assign channel_index = s_tdata[35:32];
  assign cfg_reg       = cfg_reg_t'(cfg_index);

  // Handshakes: stage one moves on whenever the output register frees up; refuse beats in reset
  assign cfg_ready = !rst;
  assign s1_adv    = !out_valid || m_tready;
  assign s_tready  = !rst && (!s1_valid || s1_adv);
  assign accept    = s_tvalid && s_tready;

  // Width since the previous capture and its classification
  assign take_cap = accept && (action == ACT_CAPTURE) && decoder_on;
  assign pulse_w  = capture_time[WIDTH_W-1:0] - prev_capture;
  assign is_sync  = (pulse_w >= sync_thr);
  assign is_pulse = (pulse_w >= min_pulse) && (pulse_w <= max_pulse);
  assign room     = (next_channel < CW'(MAX_CHANNELS));
  assign store_wr = take_cap && !is_sync && is_pulse && room;
  assign store_rd = accept && (action == ACT_READ) &&
                    ({1'b0, channel_index} < (IDX_W + 1)'(MAX_CHANNELS));

  ppm_chan_store #(
    .DEPTH (MAX_CHANNELS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (store_wr),
    .wr_addr (next_channel[AW-1:0]),
    .wr_data (pulse_w),
    .rd_en   (store_rd),
    .rd_addr (channel_index[AW-1:0]),
    .rd_data (store_data)
  );

  // Status from the state left by the item in stage one
  assign since  = now_ms - last_frame_ms;
  assign ok_now = decoder_on && frame_seen && (since < {16'd0, timeout});

  // Configuration writes; disabling drops the valid frame
  always_ff @(posedge clk) begin
    if (rst) begin
      decoder_on <= 1'b1;
      min_pulse  <= RST_MIN_PULSE;
      max_pulse  <= RST_MAX_PULSE;
      sync_thr   <= RST_SYNC_THR;
      timeout    <= RST_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg)
        REG_DECODER_ON: decoder_on <= cfg_data[0];
        REG_MIN_PULSE:  min_pulse  <= cfg_data;
        REG_MAX_PULSE:  max_pulse  <= cfg_data;
        REG_SYNC_THR:   sync_thr   <= cfg_data;
        REG_TIMEOUT:    timeout    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame tracking on captures, millisecond clock on ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      next_channel   <= '0;
      frame_channels <= '0;
      prev_capture   <= '0;
      frame_seen     <= 1'b0;
      capture_count  <= '0;
      now_ms         <= '0;
      last_frame_ms  <= '0;
    end else begin
      if (cfg_valid && cfg_ready && (cfg_reg == REG_DECODER_ON) && !cfg_data[0]) begin
        frame_seen <= 1'b0;
      end
      if (take_cap) begin
        capture_count <= capture_count + 1'b1;
        prev_capture  <= capture_time[WIDTH_W-1:0];
        if (is_sync) begin
          if (next_channel != '0) begin
            frame_channels <= next_channel;
            last_frame_ms  <= now_ms;
            frame_seen     <= 1'b1;
          end
          next_channel <= '0;
        end else if (is_pulse) begin
          if (room) begin
            next_channel <= next_channel + 1'b1;
          end
        end else begin
          next_channel <= '0;
        end
      end
      if (accept && (action == ACT_TICK)) begin
        now_ms <= now_ms + 1'b1;
      end
    end
  end

  // Stage one: hold what the item itself decided
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit    <= store_rd;
      s1_closed <= take_cap && is_sync && (next_channel != '0);
    end
  end

  // Output register: load from stage one, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_value    <= (s1_hit && frame_seen) ? store_data : '0;
      out_ok       <= ok_now;
      out_count    <= COUNT_W'(frame_channels);
      out_closed   <= s1_closed;
      out_captures <= capture_count;
      out_since    <= since;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_closed;
  assign m_tdata  = {3'd0, out_since, out_captures, out_count, out_ok, out_value};

  // Checks
  `ASSERT_CLK(a_chan_bound, clk, rst, next_channel <= CW'(MAX_CHANNELS),
    "channel pointer beyond store depth")
  `ASSERT_CLK(a_seen_needs_on, clk, rst, !frame_seen || decoder_on,
    "valid frame held while decoder disabled")
  `ASSERT_CLK(a_closed_count, clk, rst,
    !(out_valid && out_closed) || (out_count != '0) || (MAX_CHANNELS == 16),
    "frame closed with no channels")
  `ASSERT_NEXT(a_rd_hold, clk, rst, s1_valid && !s1_adv, $stable(store_data),
    "store read data changed under a stalled stage")

endmodule

// ===== bench/ppm_frame_decoder_checker.sv =====
// Checker for the PPM frame decoder: watches the input, result and register channels,
// predicts every result beat and compares it field by field. Depends on ppm_pkg.
module ppm_frame_decoder_checker
  import ppm_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] capture_time, [35:32] channel_index
  input  logic [1:0]  s_tuser,   // [1:0] action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,   // [15:0] channel_value, [16] signal_ok, [20:17] channel_count,
                                 // [52:21] capture_count, [84:53] ms_since_frame
  input  logic        m_tlast,   // frame_complete
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned frames_closed
);

  typedef struct packed {
    logic [15:0] value;
    logic        ok;
    logic [3:0]  count;
    logic        closed;
    logic [31:0] captures;
    logic [31:0] since;
  } decoder_status_t;

  // Register copies
  logic        enabled;
  logic [15:0] min_us;
  logic [15:0] max_us;
  logic [15:0] sync_us;
  logic [15:0] timeout_limit;

  // Decoder state copies
  logic [15:0] chan_store [MAX_CHANNELS];
  int unsigned next_chan;
  int unsigned frame_chans;
  logic [31:0] last_capture;
  logic        frame_seen;
  logic [31:0] capture_total;
  logic [31:0] now_ms;
  logic [31:0] frame_ms;

  decoder_status_t status_q [$];
  int unsigned     err_count;
  int unsigned     close_count;

  initial begin
    err_count     = 0;
    close_count   = 0;
  end

  task automatic clear_decoder();
    enabled       = 1'b1;
    min_us        = RST_MIN_PULSE;
    max_us        = RST_MAX_PULSE;
    sync_us       = RST_SYNC_THR;
    timeout_limit = RST_TIMEOUT;
    for (int i = 0; i < MAX_CHANNELS; i++) chan_store[i] = CENTER_US;
    next_chan     = 0;
    frame_chans   = 0;
    last_capture  = '0;
    frame_seen    = 1'b0;
    capture_total = '0;
    now_ms        = '0;
    frame_ms      = '0;
    status_q.delete();
  endtask

  // Advance the decoder copy by one item and work out its status beat
  task automatic decode_item(input logic [1:0] act, input logic [31:0] stamp,
                             input logic [3:0] idx, output decoder_status_t res);
    logic [15:0] width;
    logic [31:0] since;
    res = '0;
    case (act)
      ACT_CAPTURE: begin
        if (enabled) begin
          width = 16'(stamp - last_capture);
          capture_total = capture_total + 1;
          last_capture  = stamp;
          if (width >= sync_us) begin
            // sync gap: close the frame only if channels were taken
            if (next_chan != 0) begin
              frame_chans = next_chan;
              frame_ms    = now_ms;
              frame_seen  = 1'b1;
              res.closed  = 1'b1;
            end
            next_chan = 0;
          end else if (width >= min_us && width <= max_us) begin
            // drop pulses once the store is full
            if (next_chan < MAX_CHANNELS) begin
              chan_store[next_chan] = width;
              next_chan++;
            end
          end else begin
            next_chan = 0;
          end
        end
      end
      ACT_TICK: now_ms = now_ms + 1;
      ACT_READ: begin
        if (idx < MAX_CHANNELS && frame_seen) res.value = chan_store[idx];
      end
      default: ;
    endcase
    since        = now_ms - frame_ms;
    res.ok       = enabled && frame_seen && (since < {16'd0, timeout_limit});
    res.count    = 4'(frame_chans);
    res.captures = capture_total;
    res.since    = since;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Retire result beats, apply register writes, then predict new input beats
  always @(posedge clk) begin
    decoder_status_t want;
    decoder_status_t got;
    if (rst) begin
      clear_decoder();
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[16], m_tdata[20:17], m_tlast,
               m_tdata[52:21], m_tdata[84:53]};
        if (status_q.size() == 0) begin
          err_count++;
          $display("%0t: result beat with nothing expected, expected none, actual %0h",
                   $time, got);
        end else begin
          want = status_q.pop_front();
          check_field("channel_value", want.value, got.value);
          check_field("signal_ok", want.ok, got.ok);
          check_field("channel_count", want.count, got.count);
          check_field("frame_complete", want.closed, got.closed);
          check_field("capture_count", want.captures, got.captures);
          check_field("ms_since_frame", want.since, got.since);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DECODER_ON: begin
            enabled = cfg_data[0];
            if (!enabled) frame_seen = 1'b0;
          end
          REG_MIN_PULSE: min_us        = cfg_data;
          REG_MAX_PULSE: max_us        = cfg_data;
          REG_SYNC_THR:  sync_us       = cfg_data;
          REG_TIMEOUT:   timeout_limit = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        decode_item(s_tuser, s_tdata[31:0], s_tdata[35:32], want);
        if (want.closed) close_count++;
        status_q.push_back(want);
      end
    end
    errors        <= err_count;
    pending       <= status_q.size();
    frames_closed <= close_count;
  end

endmodule

// ===== bench/ppm_frame_decoder_test.sv =====
// Testbench top for the PPM frame decoder: clock, reset, stimulus and verdict.
// Depends on ppm_pkg, ppm_frame_decoder and ppm_frame_decoder_checker.
module ppm_frame_decoder_test;
  import ppm_pkg::*;

  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;
  localparam logic [2:0]  REG_SPARE_LO = 3'd5;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;   // [31:0] capture_time, [35:32] channel_index, rest zero
  logic [1:0]  s_tuser   = '0;   // [1:0] action
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [87:0] m_tdata;          // [15:0] channel_value, [16] signal_ok, [20:17] channel_count,
                                 // [52:21] capture_count, [84:53] ms_since_frame, rest zero
  logic        m_tlast;          // frame_complete
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  int unsigned errors;
  int unsigned pending;
  int unsigned frames_closed;

  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned items_sent  = 0;
  int unsigned reads_sent  = 0;
  int unsigned ticks_sent  = 0;
  int unsigned settings    = 0;

  // Shadow of the register values, used to shape pulse widths
  int unsigned min_us  = RST_MIN_PULSE;
  int unsigned max_us  = RST_MAX_PULSE;
  int unsigned sync_us = RST_SYNC_THR;
  int unsigned tout_ms = RST_TIMEOUT;
  logic [31:0] cur_time = '0;

  ppm_frame_decoder #(.MAX_CHANNELS(MAX_CHANNELS)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ppm_frame_decoder_checker #(.MAX_CHANNELS(MAX_CHANNELS)) u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .frames_closed(frames_closed)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_item(input logic [1:0] act, input logic [31:0] stamp,
                           input logic [3:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'd0, idx, stamp};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (act == ACT_READ) reads_sent++;
    if (act == ACT_TICK) ticks_sent++;
  endtask

  // Move the timer on by one pulse width and capture the edge
  task automatic capture_after(input int unsigned width);
    cur_time = cur_time + width;
    send_item(ACT_CAPTURE, cur_time, 4'($urandom));
  endtask

  // Hold the input side until every expected result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic on, input int unsigned lo, input int unsigned hi,
                            input int unsigned sync, input int unsigned tout);
    wait_drained();
    write_reg(REG_DECODER_ON, {15'd0, on});
    write_reg(REG_MIN_PULSE, 16'(lo));
    write_reg(REG_MAX_PULSE, 16'(hi));
    write_reg(REG_SYNC_THR, 16'(sync));
    write_reg(REG_TIMEOUT, 16'(tout));
    // unmapped index: must be ignored
    write_reg(3'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), 16'($urandom));
    min_us  = lo;
    max_us  = hi;
    sync_us = sync;
    tout_ms = tout;
    settings++;
  endtask

  // Mostly well-formed frames with random content, plus ticks, reads and noise
  task automatic run_random(input int unsigned goal);
    int unsigned start;
    int unsigned n;
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    start = items_sent;
    while (items_sent - start < goal) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        lo = min_us;
        hi = max_us;
        if (sync_us != 0 && hi >= sync_us) hi = sync_us - 1;
        n = $urandom_range(MAX_CHANNELS + 2, 1);
        repeat (n) begin
          if ($urandom_range(9) == 0) send_item(ACT_READ, $urandom, 4'($urandom));
          else if ($urandom_range(9) == 0) send_item(ACT_TICK, $urandom, 4'($urandom));
          capture_after($urandom_range(hi, lo));
        end
        capture_after($urandom_range(16'hFFFF, sync_us));
      end else if (pick < 70) begin
        n = ($urandom_range(9) == 0) ? tout_ms + 1 : $urandom_range(12, 1);
        if (n > 200) n = $urandom_range(200, 150);
        repeat (n) send_item(ACT_TICK, $urandom, 4'($urandom));
      end else if (pick < 85) begin
        send_item(ACT_READ, $urandom, 4'($urandom));
      end else if (pick < 95) begin
        if ($urandom_range(1)) begin
          cur_time = $urandom;
          send_item(ACT_CAPTURE, cur_time, 4'($urandom));
        end else begin
          capture_after($urandom_range(16'hFFFF));
        end
      end else if (pick < 98) begin
        send_item(ACT_UNUSED, $urandom, 4'($urandom));
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 31;
    rx_idle_pct = 73;

    // Directed: reset settings, window edges, empty sync, full store, timer wrap
    send_item(ACT_READ, '0, 4'd0);
    send_item(ACT_CAPTURE, '0, 4'd0);
    capture_after(RST_SYNC_THR);
    capture_after(RST_MIN_PULSE);
    capture_after(RST_MAX_PULSE);
    capture_after(RST_SYNC_THR);
    send_item(ACT_READ, '0, 4'd0);
    send_item(ACT_READ, '1, 4'd1);
    send_item(ACT_READ, '0, 4'(MAX_CHANNELS - 1));
    send_item(ACT_READ, '0, 4'hF);
    capture_after(RST_MAX_PULSE + 1);
    capture_after(RST_MIN_PULSE - 1);
    cur_time = 32'hFFFF_F000;
    send_item(ACT_CAPTURE, cur_time, 4'hF);
    repeat (MAX_CHANNELS + 1) capture_after(1000);
    capture_after(16'hFFFF);
    send_item(ACT_TICK, '1, 4'hF);
    send_item(ACT_UNUSED, '1, 4'hF);
    send_item(ACT_READ, '0, 4'(MAX_CHANNELS));

    // Random phases over several register settings
    set_config(1'b1, RST_MIN_PULSE, RST_MAX_PULSE, RST_SYNC_THR, RST_TIMEOUT);
    run_random(260);
    set_config(1'b1, 0, 16'hFFFF, 16'hFFFF, 0);
    run_random(220);

    tx_idle_pct = 73;
    rx_idle_pct = 31;
    set_config(1'b0, 1000, 2000, 2500, 16'hFFFF);
    run_random(100);
    set_config(1'b1, 1000, 2000, 2500, 16'hFFFF);
    run_random(260);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    begin
      int unsigned lo;
      int unsigned hi;
      lo = $urandom_range(2000);
      hi = lo + $urandom_range(3000);
      set_config(1'b1, lo, hi, hi + $urandom_range(5000, 1), $urandom_range(50, 1));
    end
    run_random(260);
    set_config(1'b1, 16'hFFFF, 0, 0, 16'hFFFF);
    run_random(120);

    // Drain and give the verdict
    wait_drained();
    repeat (4) @(posedge clk);
    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    $display("covered %0d items (%0d reads, %0d ticks) over %0d register settings",
             items_sent, reads_sent, ticks_sent, settings + 1);
    $display("%0d frames closed, %0d errors", frames_closed, errors);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
